[rtl/core/ahs_pkg.sv]
// ahs_pkg: shared constants and field types for the activity heap selector.
// No dependencies.
package ahs_pkg;
   localparam int VAR_CAPACITY  = 1024;
   localparam int ACTIVITY_BITS = 32;
   localparam int SLOT_BITS     = $clog2(VAR_CAPACITY);
   localparam int VAR_BITS      = SLOT_BITS + 1;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_BUMP   = 2'd0;
   localparam kind_type KIND_SET    = 2'd1;
   localparam kind_type KIND_SELECT = 2'd2;
   localparam kind_type KIND_SPARE  = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef logic [SLOT_BITS-1:0]     slot_type;
   typedef logic [VAR_BITS-1:0]      var_type;
   typedef logic [ACTIVITY_BITS-1:0] act_type;
endpackage

[rtl/core/activity_heap_select.sv]
// Each item passes through a sequencer over memories with registered reads.
// A set item, a rejected item or an unused kind goes straight to the result
// stage. A bump updates its variable's activity and then rises level by level
// (up to log2(active_vars) levels) until it stops short of the root or reaches
// it. A select examines heap slots in order until an unassigned variable turns
// up, up to active_vars slots. A configuration write, and reset, start a
// clearing pass over all VAR_CAPACITY entries (1024) during which no item is
// taken. One result per item; the result register lets the next item enter
// while the result waits, and an item only finishes once that register is
// free.
//
// activity_heap_select: top level. Uses ahs_pkg.
module activity_heap_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // var_index[10:0], increment[42:11], assigned[43]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // selected_var[10:0], status[11]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BUMP_RD, ST_BUMP_WR, ST_SIFT_RD, ST_SIFT_CMP,
      ST_SIFT_WR, ST_SEL_RD, ST_SEL_CHK, ST_SEL_TEST, ST_DONE
   } state_type;

   localparam int SB = ahs_pkg::SLOT_BITS;
   localparam int VB = ahs_pkg::VAR_BITS;

   // memories
   ahs_pkg::var_type  order_mem [ahs_pkg::VAR_CAPACITY];
   ahs_pkg::slot_type slot_mem  [ahs_pkg::VAR_CAPACITY];
   ahs_pkg::act_type  act_mem   [ahs_pkg::VAR_CAPACITY];
   logic              asg_mem   [ahs_pkg::VAR_CAPACITY];

   state_type state_ff, state_in;
   logic [VB-1:0] active_ff, active_in;
   logic [SB:0]   clr_ff, clr_in;
   ahs_pkg::slot_type vidx_ff, vidx_in;       // variable - 1
   ahs_pkg::act_type  inc_ff, inc_in;
   ahs_pkg::act_type  act_ff, act_in;          // sifting variable's activity
   ahs_pkg::slot_type slot_ff, slot_in;
   ahs_pkg::var_type  pvar_ff, pvar_in;
   logic [SB:0]   scan_ff, scan_in;
   ahs_pkg::var_type sel_ff, sel_in;           // result being built
   logic          stat_ff, stat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ahs_pkg::var_type rsp_sel_ff, rsp_sel_in;
   logic          rsp_stat_ff, rsp_stat_in;

   // memory ports (driven from control)
   logic              ord_we_a, ord_we_b, slot_we_a, slot_we_b, act_we, asg_we;
   ahs_pkg::slot_type ord_wa_a, ord_wa_b, slot_wa_a, slot_wa_b, act_wa, asg_wa;
   ahs_pkg::var_type  ord_wd_a, ord_wd_b;
   ahs_pkg::slot_type slot_wd_a, slot_wd_b;
   ahs_pkg::act_type  act_wd;
   logic              asg_wd;
   ahs_pkg::slot_type ord_ra, slot_ra, act_ra, asg_ra;
   ahs_pkg::var_type  ord_rd;
   ahs_pkg::slot_type slot_rd;
   ahs_pkg::act_type  act_rd;
   logic              asg_rd;

   always_ff @(posedge clock) begin
      if (ord_we_a) order_mem[ord_wa_a] <= ord_wd_a;
      if (ord_we_b) order_mem[ord_wa_b] <= ord_wd_b;
      if (slot_we_a) slot_mem[slot_wa_a] <= slot_wd_a;
      if (slot_we_b) slot_mem[slot_wa_b] <= slot_wd_b;
      if (act_we) act_mem[act_wa] <= act_wd;
      if (asg_we) asg_mem[asg_wa] <= asg_wd;
      ord_rd  <= order_mem[ord_ra];
      slot_rd <= slot_mem[slot_ra];
      act_rd  <= act_mem[act_ra];
      asg_rd  <= asg_mem[asg_ra];
   end

   logic [VB-1:0] req_var;
   logic [31:0]   req_inc;
   logic          req_asg, req_ok, accept, rsp_free;
   ahs_pkg::kind_type req_kind;
   ahs_pkg::slot_type parent;
   logic [ahs_pkg::ACTIVITY_BITS:0] sum;
   logic [VB-1:0] cfg_val;

   assign req_var  = req_tdata[10:0];
   assign req_inc  = req_tdata[42:11];
   assign req_asg  = req_tdata[43];
   assign req_kind = req_tuser;
   assign req_ok   = (req_var != '0) && (req_var <= active_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign accept   = req_tvalid && req_tready;
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign parent   = (slot_ff - 1'b1) >> 1;
   assign sum      = {1'b0, act_rd} + {1'b0, inc_ff};
   assign cfg_val  = (csr_data == '0) ? VB'(1)
                   : (csr_data > VB'(ahs_pkg::VAR_CAPACITY)) ? VB'(ahs_pkg::VAR_CAPACITY)
                   : csr_data;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_stat_ff, rsp_sel_ff};

   always_comb begin
      state_in = state_ff; active_in = active_ff; clr_in = clr_ff;
      vidx_in = vidx_ff; inc_in = inc_ff; act_in = act_ff; slot_in = slot_ff;
      pvar_in = pvar_ff; scan_in = scan_ff;
      sel_in = sel_ff; stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sel_in = rsp_sel_ff; rsp_stat_in = rsp_stat_ff;
      ord_we_a = 1'b0; ord_we_b = 1'b0; slot_we_a = 1'b0; slot_we_b = 1'b0;
      act_we = 1'b0; asg_we = 1'b0;
      ord_wa_a = clr_ff[SB-1:0]; ord_wd_a = VB'(clr_ff) + 1'b1;
      ord_wa_b = '0; ord_wd_b = '0;
      slot_wa_a = clr_ff[SB-1:0]; slot_wd_a = clr_ff[SB-1:0];
      slot_wa_b = '0; slot_wd_b = '0;
      act_wa = clr_ff[SB-1:0]; act_wd = '0;
      asg_wa = clr_ff[SB-1:0]; asg_wd = 1'b0;
      ord_ra = slot_ff; slot_ra = vidx_ff; act_ra = vidx_ff; asg_ra = vidx_ff;
      case (state_ff)
         ST_CLEAR: begin
            ord_we_a = 1'b1; slot_we_a = 1'b1; act_we = 1'b1; asg_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SB+1)'(ahs_pkg::VAR_CAPACITY - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               active_in = cfg_val; clr_in = '0; state_in = ST_CLEAR;
            end else if (accept) begin
               vidx_in = SB'(req_var - 1'b1);
               inc_in = req_inc;
               sel_in = '0; stat_in = ahs_pkg::STATUS_OK;
               scan_in = '0;
               act_ra = SB'(req_var - 1'b1); slot_ra = SB'(req_var - 1'b1);
               case (req_kind)
                  ahs_pkg::KIND_BUMP: begin
                     if (req_ok) state_in = ST_BUMP_RD;
                     else begin
                        stat_in = ahs_pkg::STATUS_BAD; state_in = ST_DONE;
                     end
                  end
                  ahs_pkg::KIND_SET: begin
                     if (req_ok) begin
                        asg_we = 1'b1; asg_wa = SB'(req_var - 1'b1); asg_wd = req_asg;
                     end else stat_in = ahs_pkg::STATUS_BAD;
                     state_in = ST_DONE;
                  end
                  ahs_pkg::KIND_SELECT: state_in = ST_SEL_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_BUMP_RD: state_in = ST_BUMP_WR;  // read data lands
         ST_BUMP_WR: begin
            act_in = sum[ahs_pkg::ACTIVITY_BITS] ? '1 : sum[ahs_pkg::ACTIVITY_BITS-1:0];
            act_we = 1'b1; act_wa = vidx_ff; act_wd = act_in;
            slot_in = slot_rd;
            state_in = ST_SIFT_RD;
         end
         ST_SIFT_RD: begin
            // fetch parent's variable
            if (slot_ff == '0 || VB'(slot_ff) >= active_ff) state_in = ST_DONE;
            else begin
               ord_ra = parent; state_in = ST_SIFT_CMP;
            end
         end
         ST_SIFT_CMP: begin
            pvar_in = ord_rd;
            act_ra = SB'(ord_rd - 1'b1);
            state_in = ST_SIFT_WR;
         end
         ST_SIFT_WR: begin
            if (act_ff > act_rd) begin
               ord_we_a = 1'b1; ord_wa_a = parent; ord_wd_a = VB'(vidx_ff) + 1'b1;
               ord_we_b = 1'b1; ord_wa_b = slot_ff; ord_wd_b = pvar_ff;
               slot_we_a = 1'b1; slot_wa_a = vidx_ff; slot_wd_a = parent;
               slot_we_b = 1'b1; slot_wa_b = SB'(pvar_ff - 1'b1); slot_wd_b = slot_ff;
               slot_in = parent;
               state_in = ST_SIFT_RD;
            end else state_in = ST_DONE;
         end
         ST_SEL_RD: begin
            if (VB'(scan_ff) >= active_ff) state_in = ST_DONE;
            else begin
               ord_ra = scan_ff[SB-1:0]; state_in = ST_SEL_CHK;
            end
         end
         ST_SEL_CHK: begin
            // variable at this slot is known; fetch its flag
            asg_ra = SB'(ord_rd - 1'b1);
            sel_in = ord_rd;
            scan_in = scan_ff + 1'b1;
            state_in = ST_SEL_TEST;
         end
         ST_SEL_TEST: begin
            if (asg_rd) begin
               sel_in = '0; state_in = ST_SEL_RD;
            end else state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in = sel_ff;
               rsp_stat_in = stat_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         active_ff <= VB'(ahs_pkg::VAR_CAPACITY);
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         slot_ff <= '0;
         scan_ff <= '0;
         rsp_sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff <= slot_in;
         scan_ff <= scan_in;
         rsp_sel_ff <= rsp_sel_in;
      end
      vidx_ff <= vidx_in;
      inc_ff <= inc_in;
      act_ff <= act_in;
      pvar_ff <= pvar_in;
      sel_ff <= sel_in;
      stat_ff <= stat_in;
      rsp_stat_ff <= rsp_stat_in;
   end
endmodule
